// File: rtl/hrtf_bilinear_interpolator_top_assert.svh
// ----------------------------------------------------------------------------
// hrtf_bilinear_interpolator_top_assert.svh
// assertion macros used by the interpolator top level
// ----------------------------------------------------------------------------
`ifndef HRTF_BILINEAR_INTERPOLATOR_TOP_ASSERT_SVH
`define HRTF_BILINEAR_INTERPOLATOR_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define HBI_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define HBI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/hbi_pkg.sv
// ----------------------------------------------------------------------------
// hbi_pkg
// constants, types and helpers of the bilinear filter interpolator
// ----------------------------------------------------------------------------
package hbi_pkg;

	// table geometry
	localparam int TAP_COUNT       = 32;
	localparam int ELEVATION_ROWS  = 7;
	localparam int AZIMUTH_COLUMNS = 24;
	localparam int TAB_DEPTH       = ELEVATION_ROWS * AZIMUTH_COLUMNS * TAP_COUNT;
	localparam int ADDR_W          = $clog2(TAB_DEPTH);

	// field widths
	localparam int TAP_W  = 6;
	localparam int ROW_W  = 3;
	localparam int COL_W  = 5;
	localparam int SAMP_W = 16;

	// angle grid in 1/64 degree
	localparam int GRID_STEP  = 960;
	localparam int FULL_TURN  = 23040;
	localparam int ELEV_LIMIT = 2880;
	localparam int AZW_W      = 15;
	localparam int ELV_W      = 13;
	localparam int FRAC_W     = 10;

	// divide by 960 as (x >> 6) * 547 >> 13, exact for x >> 6 below 630
	localparam int STEP_SHIFT  = 6;
	localparam int DIV15_MUL   = 547;
	localparam int DIV15_SHIFT = 13;

	// weighted sum and its scaling back to a sample
	localparam int WGT_W       = 2 * FRAC_W;
	localparam int PROD_W      = SAMP_W + WGT_W + 1;
	localparam int ACC_W       = PROD_W + 1;
	localparam int ROUND_HALF  = 460800;
	localparam int ROUND_SHIFT = 12;
	localparam int DIV_OFFSET  = 32768 * 225;
	localparam int QUOT_W      = 24;
	localparam int RECIP       = 19088744;
	localparam int RECIP_W     = 25;
	localparam int RECIP_SHIFT = 32;

	// input word kinds and ear select
	localparam logic ACTION_LOAD  = 1'b0;
	localparam logic ACTION_QUERY = 1'b1;
	localparam logic EAR_LEFT     = 1'b0;
	localparam logic EAR_RIGHT    = 1'b1;

	typedef logic [ADDR_W-1:0] addr_t;

	// table write from a load word
	typedef struct packed {
		logic                     en;
		logic                     ear;
		addr_t                    addr;
		logic signed [SAMP_W-1:0] value;
	} tab_wr_t;

	// one corner read issued by the sequencer
	typedef struct packed {
		logic              valid;
		addr_t             addr;
		logic [FRAC_W-1:0] wa;
		logic [FRAC_W-1:0] we;
		logic              first;
		logic              fin;
		logic [TAP_W-1:0]  tap;
		logic              last;
	} issue_t;

	// one finished tap
	typedef struct packed {
		logic                     valid;
		logic [TAP_W-1:0]         tap;
		logic                     last;
		logic signed [SAMP_W-1:0] left;
		logic signed [SAMP_W-1:0] right;
	} result_t;

	// table address of one tap of one grid point
	function automatic addr_t tab_addr(input logic [ROW_W-1:0] row,
		input logic [COL_W-1:0] col, input logic [TAP_W-1:0] tap);
		int a;
		a = (int'(row) * AZIMUTH_COLUMNS + int'(col)) * TAP_COUNT + int'(tap);
		return addr_t'(a);
	endfunction

endpackage

// File: rtl/hbi_blend.sv
// ----------------------------------------------------------------------------
// hbi_blend
// filter table memories and the shared multiply-accumulate pipeline that
// weights four corner taps per ear and scales the sum back to a sample
// ----------------------------------------------------------------------------
module hbi_blend (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  hbi_pkg::tab_wr_t wr,
	input  hbi_pkg::issue_t  iss,
	output hbi_pkg::result_t res
);

	logic signed [hbi_pkg::SAMP_W-1:0] mem_l [hbi_pkg::TAB_DEPTH];
	logic signed [hbi_pkg::SAMP_W-1:0] mem_r [hbi_pkg::TAB_DEPTH];

	logic signed [hbi_pkg::SAMP_W-1:0] rd_l_s1, rd_r_s1;
	logic [hbi_pkg::WGT_W-1:0]         wgt_s1;
	logic signed [hbi_pkg::PROD_W-1:0] prod_l_s2, prod_r_s2;
	logic signed [hbi_pkg::ACC_W-1:0]  acc_l_s3, acc_r_s3;
	logic [hbi_pkg::QUOT_W-1:0]        y_l_s4, y_r_s4;
	logic [hbi_pkg::SAMP_W-1:0]        q_l_s5, q_r_s5;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic first_s1, first_s2, fin_s1, fin_s2;
	logic last_s1, last_s2, last_s3, last_s4, last_s5;
	logic [hbi_pkg::TAP_W-1:0] tap_s1, tap_s2, tap_s3, tap_s4, tap_s5;

	// add half the full weight, shift the weighted sum down by 12 bits and bias it non-negative
	function automatic logic [hbi_pkg::QUOT_W-1:0] scale_sum(
		input logic signed [hbi_pkg::ACC_W-1:0] acc);
		logic signed [hbi_pkg::ACC_W-1:0] r;
		r = (acc + hbi_pkg::ACC_W'(hbi_pkg::ROUND_HALF)) >>> hbi_pkg::ROUND_SHIFT;
		return hbi_pkg::QUOT_W'(r + hbi_pkg::ACC_W'(hbi_pkg::DIV_OFFSET));
	endfunction

	// divide the biased value by 225 through its reciprocal
	function automatic logic [hbi_pkg::SAMP_W-1:0] div225(
		input logic [hbi_pkg::QUOT_W-1:0] y);
		logic [hbi_pkg::QUOT_W+hbi_pkg::RECIP_W-1:0] p;
		p = (hbi_pkg::QUOT_W + hbi_pkg::RECIP_W)'(y)
			* (hbi_pkg::QUOT_W + hbi_pkg::RECIP_W)'(hbi_pkg::RECIP);
		return p[hbi_pkg::RECIP_SHIFT +: hbi_pkg::SAMP_W];
	endfunction

	// left ear table: load writes, corner reads with registered data
	always_ff @(posedge clk) begin
		if (wr.en && wr.ear == hbi_pkg::EAR_LEFT)
			mem_l[wr.addr] <= wr.value;
		if (en)
			rd_l_s1 <= mem_l[iss.addr];
	end

	// right ear table
	always_ff @(posedge clk) begin
		if (wr.en && wr.ear == hbi_pkg::EAR_RIGHT)
			mem_r[wr.addr] <= wr.value;
		if (en)
			rd_r_s1 <= mem_r[iss.addr];
	end

	// valid chain, whole pipeline holds while the output is stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= iss.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && fin_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// weight, product, accumulate, round and divide stages
	always_ff @(posedge clk) begin
		if (en) begin
			wgt_s1   <= hbi_pkg::WGT_W'(iss.wa) * hbi_pkg::WGT_W'(iss.we);
			first_s1 <= iss.first;
			fin_s1   <= iss.fin;
			tap_s1   <= iss.tap;
			last_s1  <= iss.last;

			prod_l_s2 <= hbi_pkg::PROD_W'(rd_l_s1)
				* hbi_pkg::PROD_W'($signed({1'b0, wgt_s1}));
			prod_r_s2 <= hbi_pkg::PROD_W'(rd_r_s1)
				* hbi_pkg::PROD_W'($signed({1'b0, wgt_s1}));
			first_s2  <= first_s1;
			fin_s2    <= fin_s1;
			tap_s2    <= tap_s1;
			last_s2   <= last_s1;

			if (v_s2) begin
				acc_l_s3 <= (first_s2 ? '0 : acc_l_s3) + hbi_pkg::ACC_W'(prod_l_s2);
				acc_r_s3 <= (first_s2 ? '0 : acc_r_s3) + hbi_pkg::ACC_W'(prod_r_s2);
			end
			tap_s3  <= tap_s2;
			last_s3 <= last_s2;

			y_l_s4  <= scale_sum(acc_l_s3);
			y_r_s4  <= scale_sum(acc_r_s3);
			tap_s4  <= tap_s3;
			last_s4 <= last_s3;

			q_l_s5  <= div225(y_l_s4);
			q_r_s5  <= div225(y_r_s4);
			tap_s5  <= tap_s4;
			last_s5 <= last_s4;
		end
	end

	// remove the bias: a weighted mean of samples stays in sample range
	always_comb begin
		res.valid = v_s5;
		res.tap   = tap_s5;
		res.last  = last_s5;
		res.left  = $signed({~q_l_s5[hbi_pkg::SAMP_W-1], q_l_s5[hbi_pkg::SAMP_W-2:0]});
		res.right = $signed({~q_r_s5[hbi_pkg::SAMP_W-1], q_r_s5[hbi_pkg::SAMP_W-2:0]});
	end

endmodule

// File: rtl/hrtf_bilinear_interpolator_top.sv
// ----------------------------------------------------------------------------
// hrtf_bilinear_interpolator_top
// bilinear interpolation of left and right ear filters on a 15 degree grid
// ----------------------------------------------------------------------------
// usage
// - input words on s_axis; tuser selects the kind: load writes one tap of
//   one ear into the table, query asks for the interpolated filter pair
// - a load word gives no output word
// - a query gives TAP_COUNT output words on m_axis, tap 0 first, tlast on
//   the final tap; each carries the left and right interpolated taps
// - after a query the block runs the angle preparation states WRAP, SPLIT
//   and FRAC, then one shared multiply-accumulate per ear takes the four
//   corner reads of each tap in turn from the single read port of its table
// - s_axis_tready is low from the acceptance of a query until the sequencer
//   has issued the last corner of the last tap and returned to idle
// - a stall on m_axis freezes the whole read and arithmetic pipeline;
//   nothing is dropped and the sequencer simply waits
// - reset clears the sequencer and the valid flags; the table contents are
//   undefined until loaded, and queries must only touch loaded taps
// ----------------------------------------------------------------------------
`include "hrtf_bilinear_interpolator_top_assert.svh"

module hrtf_bilinear_interpolator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// azimuth[15:0], elevation[31:16], load_row[34:32], load_column[39:35],
	// load_tap[45:40], load_ear[46], load_value[62:47], zero pad[63]
	input  logic [63:0] s_axis_tdata,
	// action[0]
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tap_number[5:0], left_tap[21:6], right_tap[37:22], zero pad[39:38]
	output logic [39:0] m_axis_tdata,
	output logic        m_axis_tlast
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRAP,
		ST_SPLIT,
		ST_FRAC,
		ST_RUN
	} state_t;

	localparam logic [1:0] CORNER_FIRST = 2'd0;
	localparam logic [1:0] CORNER_LAST  = 2'd3;

	state_t state_q;
	logic [1:0] corner_q;
	logic [hbi_pkg::TAP_W-1:0] tap_q;

	// input word fields
	logic                              act;
	logic signed [15:0]                azimuth, elevation;
	logic [hbi_pkg::ROW_W-1:0]         load_row, row_clamp;
	logic [hbi_pkg::COL_W-1:0]         load_column;
	logic [hbi_pkg::TAP_W-1:0]         load_tap;
	logic                              load_ear;
	logic signed [hbi_pkg::SAMP_W-1:0] load_value;

	logic s_acc, en;

	// angle preparation registers
	logic signed [15:0]          az_q, el_q;
	logic [hbi_pkg::AZW_W-1:0]   azw_q, azw_d;
	logic [hbi_pkg::ELV_W-1:0]   elv_q, elv_d;
	logic [hbi_pkg::COL_W-1:0]   aq_q, a0_q, a1_q;
	logic [hbi_pkg::ROW_W-1:0]   rq_q, r0_q, r1_q, r0_d;
	logic [hbi_pkg::FRAC_W-1:0]  fa_q, fe_q;
	logic [17:0]                 aprod;
	logic [15:0]                 rprod;

	hbi_pkg::tab_wr_t wr;
	hbi_pkg::issue_t  iss;
	hbi_pkg::result_t res;

	logic out_valid_q, out_last_q;
	logic [hbi_pkg::TAP_W-1:0]         out_tap_q;
	logic signed [hbi_pkg::SAMP_W-1:0] out_left_q, out_right_q;

	// unpack the input word
	assign act         = s_axis_tuser;
	assign azimuth     = s_axis_tdata[15:0];
	assign elevation   = s_axis_tdata[31:16];
	assign load_row    = s_axis_tdata[34:32];
	assign load_column = s_axis_tdata[39:35];
	assign load_tap    = s_axis_tdata[45:40];
	assign load_ear    = s_axis_tdata[46];
	assign load_value  = s_axis_tdata[62:47];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign en            = !out_valid_q || m_axis_tready;

	// load path: clamp the row, drop out-of-range columns and taps
	always_comb begin
		row_clamp = (load_row > hbi_pkg::ROW_W'(hbi_pkg::ELEVATION_ROWS - 1))
			? hbi_pkg::ROW_W'(hbi_pkg::ELEVATION_ROWS - 1) : load_row;
		wr.en    = s_acc && act == hbi_pkg::ACTION_LOAD
			&& load_column < hbi_pkg::COL_W'(hbi_pkg::AZIMUTH_COLUMNS)
			&& int'(load_tap) < hbi_pkg::TAP_COUNT;
		wr.ear   = load_ear;
		wr.addr  = hbi_pkg::tab_addr(row_clamp, load_column, load_tap);
		wr.value = load_value;
	end

	// azimuth wrap into one turn, elevation clamp and offset to row 0
	always_comb begin
		if (az_q < -hbi_pkg::FULL_TURN)
			azw_d = hbi_pkg::AZW_W'(17'(az_q) + 17'(2 * hbi_pkg::FULL_TURN));
		else if (az_q < 0)
			azw_d = hbi_pkg::AZW_W'(17'(az_q) + 17'(hbi_pkg::FULL_TURN));
		else if (az_q >= hbi_pkg::FULL_TURN)
			azw_d = hbi_pkg::AZW_W'(17'(az_q) - 17'(hbi_pkg::FULL_TURN));
		else
			azw_d = hbi_pkg::AZW_W'(az_q);
		if (el_q < -hbi_pkg::ELEV_LIMIT)
			elv_d = '0;
		else if (el_q > hbi_pkg::ELEV_LIMIT)
			elv_d = hbi_pkg::ELV_W'(2 * hbi_pkg::ELEV_LIMIT);
		else
			elv_d = hbi_pkg::ELV_W'(17'(el_q) + 17'(hbi_pkg::ELEV_LIMIT));
	end

	// grid index by reciprocal multiply, row clamp for the lower corner
	always_comb begin
		aprod = 18'(azw_q >> hbi_pkg::STEP_SHIFT) * 18'(hbi_pkg::DIV15_MUL);
		rprod = 16'(elv_q >> hbi_pkg::STEP_SHIFT) * 16'(hbi_pkg::DIV15_MUL);
		r0_d  = (rq_q > hbi_pkg::ROW_W'(hbi_pkg::ELEVATION_ROWS - 1))
			? hbi_pkg::ROW_W'(hbi_pkg::ELEVATION_ROWS - 1) : rq_q;
	end

	// angle preparation, one step per state
	always_ff @(posedge clk) begin
		if (s_acc) begin
			az_q <= azimuth;
			el_q <= elevation;
		end
		if (state_q == ST_WRAP) begin
			azw_q <= azw_d;
			elv_q <= elv_d;
		end
		if (state_q == ST_SPLIT) begin
			aq_q <= hbi_pkg::COL_W'(aprod >> hbi_pkg::DIV15_SHIFT);
			rq_q <= hbi_pkg::ROW_W'(rprod >> hbi_pkg::DIV15_SHIFT);
		end
		if (state_q == ST_FRAC) begin
			fa_q <= hbi_pkg::FRAC_W'(azw_q
				- hbi_pkg::AZW_W'(aq_q) * hbi_pkg::AZW_W'(hbi_pkg::GRID_STEP));
			fe_q <= hbi_pkg::FRAC_W'(elv_q
				- hbi_pkg::ELV_W'(rq_q) * hbi_pkg::ELV_W'(hbi_pkg::GRID_STEP));
			a0_q <= aq_q;
			a1_q <= (aq_q == hbi_pkg::COL_W'(hbi_pkg::AZIMUTH_COLUMNS - 1))
				? '0 : aq_q + 1'b1;
			r0_q <= r0_d;
			r1_q <= (r0_d == hbi_pkg::ROW_W'(hbi_pkg::ELEVATION_ROWS - 1))
				? r0_d : r0_d + 1'b1;
		end
	end

	// sequencer: preparation steps, then four corners per tap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			corner_q <= CORNER_FIRST;
			tap_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_acc && act == hbi_pkg::ACTION_QUERY)
						state_q <= ST_WRAP;
				end
				ST_WRAP:  state_q <= ST_SPLIT;
				ST_SPLIT: state_q <= ST_FRAC;
				ST_FRAC:  state_q <= ST_RUN;
				ST_RUN: begin
					if (en) begin
						corner_q <= corner_q + 1'b1;
						if (corner_q == CORNER_LAST) begin
							if (iss.last) begin
								tap_q   <= '0;
								state_q <= ST_IDLE;
							end else begin
								tap_q <= tap_q + 1'b1;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// corner read: bit 0 steps the column, bit 1 steps the row
	always_comb begin
		iss.valid = (state_q == ST_RUN);
		iss.addr  = hbi_pkg::tab_addr(corner_q[1] ? r1_q : r0_q,
			corner_q[0] ? a1_q : a0_q, tap_q);
		iss.wa    = corner_q[0] ? fa_q : hbi_pkg::FRAC_W'(hbi_pkg::GRID_STEP) - fa_q;
		iss.we    = corner_q[1] ? fe_q : hbi_pkg::FRAC_W'(hbi_pkg::GRID_STEP) - fe_q;
		iss.first = (corner_q == CORNER_FIRST);
		iss.fin   = (corner_q == CORNER_LAST);
		iss.tap   = tap_q;
		iss.last  = (tap_q == hbi_pkg::TAP_W'(hbi_pkg::TAP_COUNT - 1));
	end

	hbi_blend u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.wr     (wr),
		.iss    (iss),
		.res    (res)
	);

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (en)
			out_valid_q <= res.valid;
	end

	always_ff @(posedge clk) begin
		if (en && res.valid) begin
			out_tap_q   <= res.tap;
			out_last_q  <= res.last;
			out_left_q  <= res.left;
			out_right_q <= res.right;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {2'b00, out_right_q, out_left_q, out_tap_q};

	// checks
	`HBI_ASSERT_IMPLY(a_frac_in_step, state_q == ST_RUN,
		fa_q < hbi_pkg::FRAC_W'(hbi_pkg::GRID_STEP)
		&& fe_q < hbi_pkg::FRAC_W'(hbi_pkg::GRID_STEP), "grid fraction out of step")
	`HBI_ASSERT_IMPLY(a_last_tap_number, m_axis_tvalid && m_axis_tlast,
		out_tap_q == hbi_pkg::TAP_W'(hbi_pkg::TAP_COUNT - 1), "tlast on wrong tap")
	`HBI_ASSERT_NEXT(a_run_ends_idle,
		state_q == ST_RUN && en && corner_q == CORNER_LAST && iss.last,
		state_q == ST_IDLE && tap_q == '0, "query run did not return to idle")

endmodule
